// ----- design/tgc_pkg.sv -----
package tgc_pkg;

	localparam int CoordW = 11;
	localparam int TimeW  = 32;
	localparam int DebW   = 16;
	localparam int GestW  = 3;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [TimeW-1:0]  time_ms_t;
	typedef logic [GestW-1:0]  gest_t;

	// gesture codes
	localparam gest_t GEST_NONE  = 3'd0;
	localparam gest_t GEST_LEFT  = 3'd1;
	localparam gest_t GEST_RIGHT = 3'd2;
	localparam gest_t GEST_DOWN  = 3'd3;
	localparam gest_t GEST_TAP   = 3'd4;
	localparam gest_t GEST_LONG  = 3'd5;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_SWIPE_H_MIN = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SWIPE_V_MIN = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_TAP_MAX     = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE    = 2'd3;

	// register reset values
	localparam coord_t            SWIPE_H_MIN_RST = 11'd60;
	localparam coord_t            SWIPE_V_MIN_RST = 11'd80;
	localparam coord_t            TAP_MAX_RST     = 11'd30;
	localparam logic [DebW-1:0]   DEBOUNCE_RST    = 16'd100;

	// thresholds handed to the classifier
	typedef struct packed {
		coord_t swipe_h_min;
		coord_t swipe_v_min;
		coord_t tap_max;
	} cls_cfg_t;

endpackage

// ----- design/tgc_in_if.sv -----
interface tgc_in_if;
	import tgc_pkg::*;

	logic     valid;
	logic     ready;
	logic     touched;
	coord_t   point_x_in;
	coord_t   point_y_in;
	time_ms_t now_ms;
	logic     long_press;
	logic     wake_consumed;

	modport source (
		output valid, touched, point_x_in, point_y_in, now_ms, long_press, wake_consumed,
		input  ready
	);
	modport sink (
		input  valid, touched, point_x_in, point_y_in, now_ms, long_press, wake_consumed,
		output ready
	);
endinterface

// ----- design/tgc_out_if.sv -----
interface tgc_out_if;
	import tgc_pkg::*;

	logic   valid;
	logic   ready;
	gest_t  gesture;
	coord_t point_x_out;
	coord_t point_y_out;

	modport source (
		output valid, gesture, point_x_out, point_y_out,
		input  ready
	);
	modport sink (
		input  valid, gesture, point_x_out, point_y_out,
		output ready
	);
endinterface

// ----- design/touch_gesture_classifier_core.sv -----
// touch gesture classifier: one touch sample in, one gesture beat out per sample. a sample
// is registered on acceptance; once the result register can take it, the stage logic updates
// the touch state (last point, start point, last touch-down time, previous touched flag) and
// loads the result register. a sample can be taken every cycle, so the sustained rate is one
// sample per clock while the output is not stalled; the block stalls only while the result
// register is full and the sink holds ready low. the four threshold registers are written
// through cfg_we/cfg_index/cfg_data and should only change while no sample is in flight. the
// gesture codes are 0 none, 1 swipe left, 2 swipe right, 3 swipe down, 4 tap (start point
// reported), 5 long-press (last point reported); the point is zero for every other code.
module touch_gesture_classifier_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tgc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [tgc_pkg::CfgDataW-1:0]   cfg_data,
	tgc_in_if.sink                         sample,
	tgc_out_if.source                      result
);
	import tgc_pkg::*;

	// configuration registers
	cls_cfg_t        cfg_q;
	logic [DebW-1:0] debounce_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swipe_h_min <= SWIPE_H_MIN_RST;
			cfg_q.swipe_v_min <= SWIPE_V_MIN_RST;
			cfg_q.tap_max     <= TAP_MAX_RST;
			debounce_q        <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SWIPE_H_MIN: cfg_q.swipe_h_min <= cfg_data[CoordW-1:0];
				REG_SWIPE_V_MIN: cfg_q.swipe_v_min <= cfg_data[CoordW-1:0];
				REG_TAP_MAX:     cfg_q.tap_max     <= cfg_data[CoordW-1:0];
				REG_DEBOUNCE:    debounce_q        <= cfg_data[DebW-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	logic     valid_s1;
	logic     touched_s1;
	coord_t   px_s1;
	coord_t   py_s1;
	time_ms_t now_s1;
	logic     lp_s1;
	logic     wake_s1;

	// output register
	logic   out_valid_q;
	gest_t  gesture_q;
	coord_t ox_q;
	coord_t oy_q;

	logic advance;   // stage 1 may hand its sample to the result register
	logic take_in;

	assign advance      = !out_valid_q || result.ready;
	assign sample.ready = !valid_s1 || advance;
	assign take_in      = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			touched_s1 <= sample.touched;
			px_s1      <= sample.point_x_in;
			py_s1      <= sample.point_y_in;
			now_s1     <= sample.now_ms;
			lp_s1      <= sample.long_press;
			wake_s1    <= sample.wake_consumed;
		end
	end

	// touch state
	logic     was_touched_q;
	coord_t   start_x_q;
	coord_t   start_y_q;
	coord_t   held_x_q;
	coord_t   held_y_q;
	time_ms_t last_down_q;

	logic     fire;       // stage 1 sample is consumed this cycle
	coord_t   held_x_nx;
	coord_t   held_y_nx;
	logic     touch_down;
	logic     lift;
	logic     debounce_ok;
	logic     start_take;
	time_ms_t elapsed;
	gest_t    cand;
	gest_t    gest_nx;
	coord_t   ox_nx;
	coord_t   oy_nx;

	// lift is classified against the held and start point as they stand before this sample
	tgc_classify u_classify (
		.start_x (start_x_q),
		.start_y (start_y_q),
		.held_x  (held_x_q),
		.held_y  (held_y_q),
		.cfg     (cfg_q),
		.cand    (cand)
	);

	always_comb begin
		fire        = valid_s1 && advance;
		held_x_nx   = touched_s1 ? px_s1 : held_x_q;
		held_y_nx   = touched_s1 ? py_s1 : held_y_q;
		touch_down  = touched_s1 && !was_touched_q;
		lift        = !touched_s1 && was_touched_q;
		// elapsed time wraps modulo 2^32
		elapsed     = now_s1 - last_down_q;
		debounce_ok = elapsed > TimeW'(debounce_q);
		start_take  = touch_down && debounce_ok;

		gest_nx = GEST_NONE;
		ox_nx   = '0;
		oy_nx   = '0;
		// wake suppression drops the gesture but not the state update
		if (lift && !wake_s1 && cand != GEST_NONE) begin
			gest_nx = cand;
			if (cand == GEST_TAP) begin
				ox_nx = start_x_q;
				oy_nx = start_y_q;
			end
		end
		// long-press needs touched, so it never meets a lift
		if (lp_s1 && touched_s1 && !wake_s1) begin
			gest_nx = GEST_LONG;
			ox_nx   = held_x_nx;
			oy_nx   = held_y_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_touched_q <= 1'b0;
			start_x_q     <= '0;
			start_y_q     <= '0;
			held_x_q      <= '0;
			held_y_q      <= '0;
			last_down_q   <= '0;
		end else if (fire) begin
			was_touched_q <= touched_s1;
			held_x_q      <= held_x_nx;
			held_y_q      <= held_y_nx;
			if (start_take) begin
				start_x_q   <= held_x_nx;
				start_y_q   <= held_y_nx;
				last_down_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			gesture_q <= gest_nx;
			ox_q      <= ox_nx;
			oy_q      <= oy_nx;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.gesture     = gesture_q;
	assign result.point_x_out = ox_q;
	assign result.point_y_out = oy_q;

`ifndef SYNTHESIS
	// only codes 0..5 ever leave the block
	a_gest_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> gesture_q <= GEST_LONG)
		else $error("gesture code out of range");

	// a point is reported only with a tap or a long-press
	a_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && gesture_q != GEST_TAP && gesture_q != GEST_LONG)
		|-> (ox_q == '0 && oy_q == '0))
		else $error("point reported with a gesture that carries none");

	// the touched flag of a consumed beat becomes the previous-touch state
	a_was_touched: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> was_touched_q == $past(touched_s1))
		else $error("touch state not updated from consumed beat");
`endif

endmodule

// ----- design/tgc_classify.sv -----
module tgc_classify (
	input  tgc_pkg::coord_t   start_x,
	input  tgc_pkg::coord_t   start_y,
	input  tgc_pkg::coord_t   held_x,
	input  tgc_pkg::coord_t   held_y,
	input  tgc_pkg::cls_cfg_t cfg,
	output tgc_pkg::gest_t    cand
);
	import tgc_pkg::*;

	logic signed [CoordW:0] dx;
	logic signed [CoordW:0] dy;
	coord_t adx;
	coord_t ady;

	always_comb begin
		dx  = $signed({1'b0, held_x}) - $signed({1'b0, start_x});
		dy  = $signed({1'b0, held_y}) - $signed({1'b0, start_y});
		// magnitude fits in 11 bits since |d| <= 2047
		adx = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
		ady = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];

		if (adx > cfg.swipe_h_min && adx > ady) begin
			cand = dx[CoordW] ? GEST_LEFT : GEST_RIGHT;
		end else if (!dy[CoordW] && dy[CoordW-1:0] > cfg.swipe_v_min && ady > adx) begin
			cand = GEST_DOWN;
		end else if (adx < cfg.tap_max && ady < cfg.tap_max) begin
			cand = GEST_TAP;
		end else begin
			cand = GEST_NONE;
		end
	end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import tgc_pkg::*;

	// one touch sample as it goes into the block
	typedef struct packed {
		logic     touched;
		coord_t   x;
		coord_t   y;
		time_ms_t now_ms;
		logic     long_press;
		logic     wake;
	} sample_t;

	// one gesture beat as it comes out
	typedef struct packed {
		gest_t  gesture;
		coord_t point_x;
		coord_t point_y;
	} gesture_beat_t;

	// tracks the touch state and config, holds the gesture beats still owed by the block
	class gesture_scoreboard;
		coord_t          h_min     = SWIPE_H_MIN_RST;
		coord_t          v_min     = SWIPE_V_MIN_RST;
		coord_t          tap_max   = TAP_MAX_RST;
		logic [DebW-1:0] debounce  = DEBOUNCE_RST;

		logic     was_touched = 1'b0;
		coord_t   start_x     = '0;
		coord_t   start_y     = '0;
		coord_t   held_x      = '0;
		coord_t   held_y      = '0;
		time_ms_t last_down   = '0;

		gesture_beat_t expected_gestures[$];
		int            errors = 0;

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				REG_SWIPE_H_MIN: h_min    = data[CoordW-1:0];
				REG_SWIPE_V_MIN: v_min    = data[CoordW-1:0];
				REG_TAP_MAX:     tap_max  = data[CoordW-1:0];
				REG_DEBOUNCE:    debounce = data[DebW-1:0];
				default: ;
			endcase
		endfunction

		function gesture_beat_t classify_sample(sample_t s);
			gesture_beat_t r;
			time_ms_t      elapsed;
			int            dx, dy, adx, ady;
			gest_t         cand;
			r = '{GEST_NONE, '0, '0};
			if (s.touched) begin
				held_x = s.x;
				held_y = s.y;
			end
			if (s.touched && !was_touched) begin
				elapsed = s.now_ms - last_down;
				if (elapsed > time_ms_t'(debounce)) begin
					start_x   = held_x;
					start_y   = held_y;
					last_down = s.now_ms;
				end
			end
			if (!s.touched && was_touched) begin
				dx   = int'(held_x) - int'(start_x);
				dy   = int'(held_y) - int'(start_y);
				adx  = (dx < 0) ? -dx : dx;
				ady  = (dy < 0) ? -dy : dy;
				cand = GEST_NONE;
				if (adx > int'(h_min) && adx > ady)
					cand = (dx < 0) ? GEST_LEFT : GEST_RIGHT;
				else if (dy > int'(v_min) && ady > adx)
					cand = GEST_DOWN;
				else if (adx < int'(tap_max) && ady < int'(tap_max))
					cand = GEST_TAP;
				if (!s.wake && cand != GEST_NONE) begin
					r.gesture = cand;
					if (cand == GEST_TAP) begin
						r.point_x = start_x;
						r.point_y = start_y;
					end
				end
			end
			if (s.long_press && s.touched && !s.wake)
				r = '{GEST_LONG, held_x, held_y};
			was_touched = s.touched;
			return r;
		endfunction

		function void note_sample(sample_t s);
			expected_gestures.push_back(classify_sample(s));
		endfunction

		function void check_result(gest_t g, coord_t x, coord_t y);
			gesture_beat_t want;
			if (expected_gestures.size() == 0) begin
				$display("%0t: gesture beat %0d at (%0d,%0d) with nothing expected", $time, g, x, y);
				errors++;
				return;
			end
			want = expected_gestures.pop_front();
			if (g !== want.gesture) begin
				$display("%0t: gesture expected %0d actual %0d", $time, want.gesture, g);
				errors++;
			end
			if (x !== want.point_x) begin
				$display("%0t: point_x expected %0d actual %0d", $time, want.point_x, x);
				errors++;
			end
			if (y !== want.point_y) begin
				$display("%0t: point_y expected %0d actual %0d", $time, want.point_y, y);
				errors++;
			end
		endfunction
	endclass

	localparam int WatchdogLimit  = 2000;
	localparam int ItemsPerPhase  = 250;
	localparam int NumPhases      = 6;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	tgc_in_if  sample_ch ();
	tgc_out_if result_ch ();

	gesture_scoreboard sb = new();

	time_ms_t ms_clock     = '0;	// running touch-controller time
	int       items_sent   = 0;
	int       burst_left   = 0;
	int       idle_cycles  = 0;
	int       stall_mode   = 0;
	int       stall_left   = 0;

	touch_gesture_classifier_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always #4 clk = ~clk;

	// input beats go to the predictor, output beats get checked
	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready)
			sb.note_sample('{sample_ch.touched, sample_ch.point_x_in, sample_ch.point_y_in,
				sample_ch.now_ms, sample_ch.long_press, sample_ch.wake_consumed});
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.gesture, result_ch.point_x_out, result_ch.point_y_out);
	end

	// receiver back-pressure: stretches of always-ready, coin-flip and mostly-stalled
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= 1'($urandom_range(0, 1));
			default: result_ch.ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// watchdog: too long without a beat on either side means the block hung
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WatchdogLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// drive one sample and hold it until the block takes it; bursts with random gaps
	task automatic push_sample(sample_t s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_ch.valid         <= 1'b1;
		sample_ch.touched       <= s.touched;
		sample_ch.point_x_in    <= s.x;
		sample_ch.point_y_in    <= s.y;
		sample_ch.now_ms        <= s.now_ms;
		sample_ch.long_press    <= s.long_press;
		sample_ch.wake_consumed <= s.wake;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic push_fields(int t, int x, int y, time_ms_t now, int lp, int wake);
		push_sample('{1'(t), coord_t'(x), coord_t'(y), now, 1'(lp), 1'(wake)});
	endtask

	// stop sending and let every owed gesture beat come out
	task automatic wait_drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_gestures.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all four thresholds back to back, block must be idle
	task automatic program_regs(logic [CfgDataW-1:0] h, v, t, d);
		logic [CfgIdxW-1:0]  regs [4];
		logic [CfgDataW-1:0] vals [4];
		regs = '{REG_SWIPE_H_MIN, REG_SWIPE_V_MIN, REG_TAP_MAX, REG_DEBOUNCE};
		vals = '{h, v, t, d};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			sb.set_reg(regs[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic coord_t clamp_coord(int v);
		if (v < 0)
			return '0;
		if (v > 2047)
			return 11'd2047;
		return coord_t'(v);
	endfunction

	// start coordinate so that start plus offset stays on the panel where possible
	function automatic int fit_start(int offset);
		int s;
		s = $urandom_range(0, 2047);
		if (s + offset > 2047)
			s = 2047 - offset;
		if (s + offset < 0)
			s = -offset;
		return s;
	endfunction

	// distances that sit on, just around, or far off a threshold
	function automatic int near_mag(int thr);
		case ($urandom_range(0, 3))
			0: return (thr == 0) ? int'($urandom_range(0, 1)) : thr + int'($urandom_range(0, 2)) - 1;
			1: return thr + int'($urandom_range(1, 200));
			2: return int'($urandom_range(0, thr));
			default: return int'($urandom_range(0, 2047));
		endcase
	endfunction

	// a full touch-down, move, lift sequence aimed at one kind of gesture
	task automatic run_gesture();
		int      dxo, dyo, m, sgn, holds, sx, sy, tx, ty;
		bit      with_lp;
		sample_t s;
		sgn = $urandom_range(0, 1) ? 1 : -1;
		case ($urandom_range(0, 5))
			0: begin
				dxo = -near_mag(int'(sb.h_min));
				dyo = int'($urandom_range(0, 20)) - 10;
			end
			1: begin
				dxo = near_mag(int'(sb.h_min));
				dyo = int'($urandom_range(0, 20)) - 10;
			end
			2: begin
				dyo = near_mag(int'(sb.v_min));
				dxo = int'($urandom_range(0, 20)) - 10;
			end
			3: begin
				dxo = near_mag(int'(sb.tap_max)) * sgn;
				dyo = near_mag(int'(sb.tap_max)) * ($urandom_range(0, 1) ? 1 : -1);
			end
			4: begin
				// diagonal, often with |dx| equal to |dy|
				m   = near_mag(int'(sb.h_min));
				dxo = m * sgn;
				dyo = (m + int'($urandom_range(0, 2)) - 1) * ($urandom_range(0, 1) ? 1 : -1);
			end
			default: begin
				dxo = int'($urandom_range(0, 4094)) - 2047;
				dyo = int'($urandom_range(0, 4094)) - 2047;
			end
		endcase
		sx = fit_start(dxo);
		sy = fit_start(dyo);
		tx = sx + dxo;
		ty = sy + dyo;
		holds   = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 5);
		with_lp = ($urandom_range(0, 3) == 0);

		// gap before touch-down: mostly past debounce, sometimes inside it, rarely a wild jump
		case ($urandom_range(0, 39))
			0:       ms_clock = $urandom;
			1, 2, 3, 4, 5, 6: ms_clock += $urandom_range(0, sb.debounce);
			default: ms_clock += time_ms_t'(sb.debounce) + 1 + $urandom_range(0, 500);
		endcase

		for (int i = 0; i < holds; i++) begin
			s.touched = 1'b1;
			if (i == 0) begin
				s.x = clamp_coord(sx);
				s.y = clamp_coord(sy);
			end else if (i == holds - 1) begin
				s.x = clamp_coord(tx);
				s.y = clamp_coord(ty);
			end else begin
				s.x = clamp_coord(sx + dxo * i / holds + int'($urandom_range(0, 6)) - 3);
				s.y = clamp_coord(sy + dyo * i / holds + int'($urandom_range(0, 6)) - 3);
			end
			s.now_ms     = ms_clock;
			s.long_press = with_lp && $urandom_range(0, 1);
			s.wake       = ($urandom_range(0, 7) == 0);
			push_sample(s);
			ms_clock += $urandom_range(1, 40);
		end

		// lift: coordinates are don't-care here but still toggle
		s.touched    = 1'b0;
		s.x          = coord_t'($urandom_range(0, 2047));
		s.y          = coord_t'($urandom_range(0, 2047));
		s.now_ms     = ms_clock;
		s.long_press = ($urandom_range(0, 7) == 0);
		s.wake       = ($urandom_range(0, 4) == 0);
		push_sample(s);
		ms_clock += $urandom_range(1, 40);
	endtask

	// unstructured sample: stray lifts, double touch-downs, odd flags
	task automatic push_noise();
		sample_t s;
		s.touched    = 1'($urandom_range(0, 1));
		s.x          = coord_t'($urandom_range(0, 2047));
		s.y          = coord_t'($urandom_range(0, 2047));
		s.long_press = 1'($urandom_range(0, 1));
		s.wake       = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0)
			ms_clock = $urandom;
		else
			ms_clock += $urandom_range(0, 300);
		s.now_ms = ms_clock;
		push_sample(s);
	endtask

	initial begin
		int target;

		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= '0;
		cfg_data                <= '0;
		sample_ch.valid         <= 1'b0;
		sample_ch.touched       <= 1'b0;
		sample_ch.point_x_in    <= '0;
		sample_ch.point_y_in    <= '0;
		sample_ch.now_ms        <= '0;
		sample_ch.long_press    <= 1'b0;
		sample_ch.wake_consumed <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, thresholds at reset values
		// swipe left
		push_fields(1, 1000, 1000, 200, 0, 0);
		push_fields(1, 900, 1010, 210, 0, 0);
		push_fields(0, 0, 0, 220, 0, 0);
		// swipe right
		push_fields(1, 100, 100, 400, 0, 0);
		push_fields(1, 300, 120, 410, 0, 0);
		push_fields(0, 2047, 2047, 420, 0, 0);
		// swipe down
		push_fields(1, 500, 500, 600, 0, 0);
		push_fields(1, 505, 700, 610, 0, 0);
		push_fields(0, 0, 0, 620, 0, 0);
		// tap at the far corner
		push_fields(1, 2047, 2047, 800, 0, 0);
		push_fields(0, 0, 0, 810, 0, 0);
		// long-press at the origin, then a move too small for a swipe, too big for a tap
		push_fields(1, 0, 0, 1000, 1, 0);
		push_fields(1, 40, 0, 1010, 0, 0);
		push_fields(0, 0, 0, 1020, 0, 0);
		// touch-down inside the debounce window keeps the old start point
		push_fields(1, 10, 10, 1050, 0, 0);
		push_fields(0, 0, 0, 1060, 0, 0);
		// tap swallowed by a screen wake
		push_fields(1, 200, 200, 2000, 0, 0);
		push_fields(0, 0, 0, 2010, 0, 1);
		// long-press swallowed by a wake, following lift still taps
		push_fields(1, 200, 200, 3000, 1, 1);
		push_fields(0, 0, 0, 3010, 0, 0);
		// millisecond counter wraps between two touch-downs
		push_fields(1, 1024, 1024, 32'hFFFF_FFFF, 0, 0);
		push_fields(0, 0, 0, 32'hFFFF_FFFF, 0, 0);
		push_fields(1, 1000, 1030, 32'h0000_0070, 0, 0);
		push_fields(0, 0, 0, 32'h0000_0071, 0, 0);
		ms_clock = 32'h0000_0100;

		// random part: each phase drains, reprograms the thresholds, then runs sequences
		for (int p = 0; p < NumPhases; p++) begin
			wait_drain();
			case (p)
				0: program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
				1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: program_regs(CfgDataW'($urandom_range(0, 200)),
					CfgDataW'($urandom_range(0, 250)),
					CfgDataW'($urandom_range(0, 80)),
					CfgDataW'($urandom_range(0, 300)));
				3: program_regs(CfgDataW'($urandom_range(0, 65535)),
					CfgDataW'($urandom_range(0, 65535)),
					CfgDataW'($urandom_range(0, 65535)),
					CfgDataW'($urandom_range(0, 65535)));
				4: program_regs(CfgDataW'($urandom_range(0, 120)),
					CfgDataW'($urandom_range(0, 150)),
					CfgDataW'($urandom_range(0, 60)), 16'h0000);
				default: program_regs(CfgDataW'(SWIPE_H_MIN_RST), CfgDataW'(SWIPE_V_MIN_RST),
					CfgDataW'(TAP_MAX_RST), DEBOUNCE_RST);
			endcase
			target = items_sent + ItemsPerPhase;
			while (items_sent < target) begin
				if ($urandom_range(0, 9) == 0)
					push_noise();
				else
					run_gesture();
				// now and then hold off until the block has caught up
				if ($urandom_range(0, 150) == 0)
					wait_drain();
			end
		end

		wait_drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
